// ----- design/sso_pkg.sv -----
`default_nettype none

package sso_pkg;

   // Number of CORDIC rotations; the arctangent table has 21 nonzero entries.
   localparam int ROTATION_STEPS = 16;
   localparam int ATAN_LEN = 24;
   localparam int CORDIC_ITERS = (ROTATION_STEPS < ATAN_LEN) ? ROTATION_STEPS : ATAN_LEN;
   // Restoring passes of the heading wrap, one per power of two of 2*pi.
   localparam int WRAP_STEPS = 6;
   // The step counter serves both the rotation and the wrap passes.
   localparam int STEP_W = $clog2(CORDIC_ITERS);

   localparam int SPEED_W = 16;
   localparam int DT_W = 16;
   localparam int RADIUS_W = 16;
   localparam int INV_SEP_W = 16;
   localparam int POSE_W = 32;
   localparam int HEADING_W = 23;
   localparam int RATE_W = 24;
   localparam int ANGLE_W = 24;
   localparam int TRIG_W = 32;
   localparam int WRAP_W = 30;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 160;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SEPARATION = 2'd1;

   localparam logic [RADIUS_W-1:0] WHEEL_RADIUS_RESET = 16'd6554;
   localparam logic [INV_SEP_W-1:0] INV_SEPARATION_RESET = 16'd8192;

   localparam logic signed [ANGLE_W-1:0] PI_Q = 24'sd3294199;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q = 24'sd1647100;
   localparam logic signed [TRIG_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;

   // The wrap adds pi plus 32 turns so the value to reduce is never negative.
   localparam logic signed [WRAP_W-1:0] PI_WIDE = 30'sd3294199;
   localparam logic signed [WRAP_W-1:0] TWO_PI_WIDE = 30'sd6588398;
   localparam logic signed [WRAP_W-1:0] WRAP_BIAS = 30'sd214122935;

   typedef struct packed {
      logic              capture;
      logic              rotate;
      logic              vel_mul;
      logic              vel_sat;
      logic              pos_mul;
      logic              pos_sum;
      logic              wrap;
      logic              commit;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // Arctangent of 2^-i in Q3.20.
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ANGLE_W-1:0] value;
      unique case (idx)
         5'd0: value = 24'sd823550;
         5'd1: value = 24'sd486170;
         5'd2: value = 24'sd256879;
         5'd3: value = 24'sd130396;
         5'd4: value = 24'sd65451;
         5'd5: value = 24'sd32757;
         5'd6: value = 24'sd16383;
         5'd7: value = 24'sd8192;
         5'd8: value = 24'sd4096;
         5'd9: value = 24'sd2048;
         5'd10: value = 24'sd1024;
         5'd11: value = 24'sd512;
         5'd12: value = 24'sd256;
         5'd13: value = 24'sd128;
         5'd14: value = 24'sd64;
         5'd15: value = 24'sd32;
         5'd16: value = 24'sd16;
         5'd17: value = 24'sd8;
         5'd18: value = 24'sd4;
         5'd19: value = 24'sd2;
         5'd20: value = 24'sd1;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

`default_nettype wire

// ----- design/sso_datapath.sv -----
`default_nettype none

module sso_datapath import sso_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  dp_cmd_type             cmd,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam logic signed [63:0] RATE_HI = 64'sd8388607;
   localparam logic signed [63:0] RATE_LO = -64'sd8388608;
   localparam logic signed [63:0] POSE_HI = 64'sd2147483647;
   localparam logic signed [63:0] POSE_LO = -64'sd2147483648;

   // Round half up, then arithmetic shift right by k.
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > RATE_HI) ? RATE_HI : ((v < RATE_LO) ? RATE_LO : v);
      return c[RATE_W-1:0];
   endfunction

   function automatic logic signed [POSE_W-1:0] sat_pose(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > POSE_HI) ? POSE_HI : ((v < POSE_LO) ? POSE_LO : v);
      return c[POSE_W-1:0];
   endfunction

   logic [RADIUS_W-1:0]          radius_ff;
   logic [INV_SEP_W-1:0]         inv_sep_ff;
   logic signed [POSE_W-1:0]     pose_x_ff, pose_x_in;
   logic signed [POSE_W-1:0]     pose_y_ff, pose_y_in;
   logic signed [HEADING_W-1:0]  heading_ff, heading_in;

   logic signed [SPEED_W:0]      sum_left_ff, sum_left_in;
   logic signed [SPEED_W:0]      sum_right_ff, sum_right_in;
   logic [DT_W-1:0]              dt_ff;
   logic signed [DT_W:0]         dt_s;

   logic signed [33:0]           left_raw_ff, left_raw_in;
   logic signed [33:0]           right_raw_ff, right_raw_in;
   logic signed [34:0]           raw_sum;
   logic signed [34:0]           diff_ff, diff_in;
   logic signed [23:0]           lin_ff, lin_in;
   logic signed [51:0]           turn_prod_ff, turn_prod_in;
   logic signed [RATE_W-1:0]     turn_ff, turn_in;

   logic signed [TRIG_W-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]    z_ff, z_in;
   logic                         flip_ff, flip_in;
   logic signed [ANGLE_W-1:0]    start_angle;
   logic signed [TRIG_W-1:0]     x_shift, y_shift, cos_val, sin_val;
   logic signed [ANGLE_W-1:0]    atan_val;

   logic signed [55:0]           vx_prod_ff, vy_prod_ff;
   logic signed [RATE_W-1:0]     vx_ff, vy_ff;
   logic signed [40:0]           px_prod_ff, py_prod_ff, h_prod_ff;
   logic signed [POSE_W-1:0]     new_px_ff, new_py_ff;
   logic signed [WRAP_W-1:0]     wrap_ff, wrap_in, wrap_limit;

   logic signed [RATE_W-1:0]     out_vx_ff, out_vy_ff, out_turn_ff;

   // Wheel sums of the request; both sides carry one extra bit.
   assign sum_left_in  = $signed({req_tdata[15], req_tdata[15:0]})
                       + $signed({req_tdata[47], req_tdata[47:32]});
   assign sum_right_in = $signed({req_tdata[31], req_tdata[31:16]})
                       + $signed({req_tdata[63], req_tdata[63:48]});
   assign dt_s = $signed({1'b0, dt_ff});

   // Side speeds, linear speed and turn rate settle in four registered steps.
   assign left_raw_in  = sum_left_ff * $signed({1'b0, radius_ff});
   assign right_raw_in = sum_right_ff * $signed({1'b0, radius_ff});
   assign raw_sum      = {left_raw_ff[33], left_raw_ff} + {right_raw_ff[33], right_raw_ff}
                       + 35'sd512;
   assign lin_in       = raw_sum[33:10];
   assign diff_in      = {right_raw_ff[33], right_raw_ff} - {left_raw_ff[33], left_raw_ff};
   assign turn_prod_in = diff_ff * $signed({1'b0, inv_sep_ff});
   assign turn_in      = sat_rate(rnd(turn_prod_ff, 21));

   // The old heading is folded into [-pi/2, pi/2]; a fold negates the cosine and sine.
   assign start_angle = {heading_ff[HEADING_W-1], heading_ff};

   always_comb begin
      flip_in = 1'b0;
      z_in    = start_angle;
      if (start_angle > HALF_PI_Q) begin
         z_in    = start_angle - PI_Q;
         flip_in = 1'b1;
      end else if (start_angle < -HALF_PI_Q) begin
         z_in    = start_angle + PI_Q;
         flip_in = 1'b1;
      end
   end

   assign x_shift  = x_ff >>> cmd.step;
   assign y_shift  = y_ff >>> cmd.step;
   assign atan_val = atan_entry(5'(cmd.step));

   always_comb begin
      if (!z_ff[ANGLE_W-1]) begin
         x_in = x_ff - y_shift;
         y_in = y_ff + x_shift;
      end else begin
         x_in = x_ff + y_shift;
         y_in = y_ff - x_shift;
      end
   end

   assign cos_val = flip_ff ? -x_ff : x_ff;
   assign sin_val = flip_ff ? -y_ff : y_ff;

   assign pose_x_in  = sat_pose(pose_x_ff + rnd(px_prod_ff, 16));
   assign pose_y_in  = sat_pose(pose_y_ff + rnd(py_prod_ff, 16));
   assign wrap_in    = WRAP_W'(heading_ff + rnd(h_prod_ff, 12) + WRAP_BIAS);
   assign wrap_limit = TWO_PI_WIDE <<< cmd.step[2:0];
   assign heading_in = HEADING_W'(wrap_ff - PI_WIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= WHEEL_RADIUS_RESET;
         inv_sep_ff <= INV_SEPARATION_RESET;
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
      end else begin
         if (csr_we) begin
            priority if (csr_index == CSR_WHEEL_RADIUS) begin
               radius_ff <= csr_wdata;
            end else if (csr_index == CSR_INV_SEPARATION) begin
               inv_sep_ff <= csr_wdata;
            end
         end
         if (cmd.commit) begin
            pose_x_ff  <= new_px_ff;
            pose_y_ff  <= new_py_ff;
            heading_ff <= heading_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      left_raw_ff  <= left_raw_in;
      right_raw_ff <= right_raw_in;
      lin_ff       <= lin_in;
      diff_ff      <= diff_in;
      turn_prod_ff <= turn_prod_in;
      turn_ff      <= turn_in;
      if (cmd.capture) begin
         sum_left_ff  <= sum_left_in;
         sum_right_ff <= sum_right_in;
         dt_ff        <= req_tdata[79:64];
         x_ff         <= CORDIC_INV_GAIN;
         y_ff         <= '0;
         z_ff         <= z_in;
         flip_ff      <= flip_in;
      end
      if (cmd.rotate) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_ff[ANGLE_W-1] ? z_ff + atan_val : z_ff - atan_val;
      end
      if (cmd.vel_mul) begin
         vx_prod_ff <= lin_ff * cos_val;
         vy_prod_ff <= lin_ff * sin_val;
      end
      if (cmd.vel_sat) begin
         vx_ff <= sat_rate(rnd(vx_prod_ff, 30));
         vy_ff <= sat_rate(rnd(vy_prod_ff, 30));
      end
      if (cmd.pos_mul) begin
         px_prod_ff <= vx_ff * dt_s;
         py_prod_ff <= vy_ff * dt_s;
         h_prod_ff  <= turn_ff * dt_s;
      end
      if (cmd.pos_sum) begin
         new_px_ff <= pose_x_in;
         new_py_ff <= pose_y_in;
         wrap_ff   <= wrap_in;
      end
      if (cmd.wrap && (wrap_ff >= wrap_limit)) begin
         wrap_ff <= wrap_ff - wrap_limit;
      end
      if (cmd.commit) begin
         out_vx_ff   <= vx_ff;
         out_vy_ff   <= vy_ff;
         out_turn_ff <= turn_ff;
      end
   end

   assign rsp_tdata = {1'b0, out_turn_ff, out_vy_ff, out_vx_ff, heading_ff, pose_y_ff, pose_x_ff};

endmodule

`default_nettype wire

// ----- design/sso_ctrl.sv -----
`default_nettype none

module sso_ctrl import sso_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ROTATE  = 3'd1;
   localparam logic [2:0] ST_VMUL    = 3'd2;
   localparam logic [2:0] ST_VSAT    = 3'd3;
   localparam logic [2:0] ST_PMUL    = 3'd4;
   localparam logic [2:0] ST_PSUM    = 3'd5;
   localparam logic [2:0] ST_WRAP    = 3'd6;
   localparam logic [2:0] ST_COMMIT  = 3'd7;

   localparam logic [STEP_W-1:0] LAST_ROTATE = STEP_W'(CORDIC_ITERS - 1);
   localparam logic [STEP_W-1:0] FIRST_WRAP  = STEP_W'(WRAP_STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.step   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               step_in     = '0;
               state_in    = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (step_ff == LAST_ROTATE) begin
               state_in = ST_VMUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_VMUL: begin
            cmd.vel_mul = 1'b1;
            state_in    = ST_VSAT;
         end
         ST_VSAT: begin
            cmd.vel_sat = 1'b1;
            state_in    = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.pos_mul = 1'b1;
            state_in    = ST_PSUM;
         end
         ST_PSUM: begin
            cmd.pos_sum = 1'b1;
            step_in     = FIRST_WRAP;
            state_in    = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.wrap = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_commit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result committed over a pending response");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   a_one_request_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while busy");

   a_rotate_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (step_ff <= LAST_ROTATE))
      else $error("rotation step beyond table");
`endif

endmodule

`default_nettype wire

// ----- design/skid_steer_odometry_unit.sv -----
`default_nettype none

// Skid-steer odometry integrator.
// Requests arrive on req_* as four wheel speeds and a time step. Each request
// yields exactly one response on rsp_* with the new pose, the world-frame
// velocity and the turn rate. Wheel radius and inverse wheel separation are
// written through csr_we/csr_index/csr_wdata only while the block is idle; the
// user is bound to this, the block itself does not enforce it. One request is
// worked on at a time: one CORDIC rotation per step, then velocity multiply,
// round and saturate, position multiply and add, six restoring passes of the
// heading wrap and one commit. req_tready returns the cycle after the commit,
// so a new request is not taken until the previous one has been committed.
// The response sits in an output register; the next request is accepted and
// computed while it waits. If rsp_tready stays low, the finished request holds
// in the commit step and the pose is not updated until the slot frees up.
// Synchronous reset clears the pose and heading to zero, loads the register
// defaults (radius 6554, inverse separation 8192) and drops rsp_tvalid.
module skid_steer_odometry_unit import sso_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Request: left_front_speed, right_front_speed, left_rear_speed,
   // right_rear_speed, time_step (16 bits each, from bit 0 up).
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Response: pose_x[31:0], pose_y[63:32], heading[86:64], velocity_x[110:87],
   // velocity_y[134:111], turn_rate[158:135], zero pad at bit 159.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Register writes: index 0 is wheel_radius, index 1 inverse_wheel_separation.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type cmd;

   // The sequencer steps the datapath through capture, rotation, scaling, position update, wrap and commit.
   sso_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Arithmetic, the pose state, the registers and the response register.
   sso_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
